// ===== sv/bdtw_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bdtw_pkg
// Shared types and constants of the banded warping aligner.
// ============================================================================
package bdtw_pkg;

    localparam int MAX_LEN_DEF     = 1024;
    localparam int MAX_WINDOW_DEF  = 31;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int            WIN_W     = 5;
    localparam logic [WIN_W-1:0] WIN_RESET = 5'd8;
    localparam int            IDX_W     = 11;
    localparam int            COST_W    = 48;

    // Cost word: bit COST_W marks "no path"
    localparam logic [COST_W:0] COST_INF = {1'b1, {COST_W{1'b0}}};
    localparam logic [COST_W:0] COST_MAX = {1'b0, {COST_W{1'b1}}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef enum logic [1:0] {
        MV_DIAG = 2'd0,
        MV_LEFT = 2'd1,
        MV_UP   = 2'd2,
        MV_NONE = 2'd3
    } t_move;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_CELL_RD,
        ST_CELL_CALC,
        ST_CELL_WR,
        ST_BT_RD,
        ST_BT_STEP,
        ST_REPORT,
        ST_RD_OUT
    } t_state;

    // Per-cell neighbour and range qualifiers handed to the cost unit
    typedef struct packed {
        logic dg_ok;
        logic lf_ok;
        logic up_ok;
        logic in_range;
    } t_cell_ctl;

endpackage

// ===== sv/bdtw_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bdtw_in_if / bdtw_out_if
// Valid/ready channels of the aligner: commands in, reports and entries out.
// ============================================================================
interface bdtw_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic                          missing_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic                          missing_b;
    logic                          last_sample;
    logic [10:0]                   path_index;

    modport source (
        output valid, operation, sample_a, missing_a, sample_b, missing_b,
               last_sample, path_index,
        input  ready
    );
    modport sink (
        input  valid, operation, sample_a, missing_a, sample_b, missing_b,
               last_sample, path_index,
        output ready
    );
endinterface

interface bdtw_out_if ();
    logic        valid;
    logic        ready;
    logic        kind;
    logic [10:0] path_length;
    logic [10:0] index_a;
    logic [10:0] index_b;
    logic        out_of_range;

    modport source (
        output valid, kind, path_length, index_a, index_b, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, kind, path_length, index_a, index_b, out_of_range,
        output ready
    );
endinterface

// ===== sv/bdtw_cost_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bdtw_cost_unit
// Local cost, neighbour minimum and saturating accumulate for one band cell.
// ============================================================================
module bdtw_cost_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int DW          = 7
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [SAMPLE_BITS:0]      i_a,
    input  logic [SAMPLE_BITS:0]      i_b,
    input  logic signed [DW-1:0]      i_d,
    input  logic [48:0]               i_dg,
    input  logic [48:0]               i_lf,
    input  logic [48:0]               i_up,
    input  bdtw_pkg::t_cell_ctl       i_ctl,
    output logic [48:0]               o_cost,
    output bdtw_pkg::t_move           o_move
);
    import bdtw_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic [SB:0]        diff;
    logic [SB:0]        mag;
    logic [33:0]        mag_x;
    logic               big;
    logic [47:0]        sq;
    logic [DW-1:0]      ad;
    logic [2*DW-1:0]    ad_sq;
    logic [COST_W-1:0]  lc_miss;
    logic [COST_W:0]    dg_e, lf_e, up_e;
    logic [COST_W-1:0]  n_lc;
    logic [COST_W:0]    n_m;
    t_move              n_mv;
    logic [COST_W-1:0]  r_lc;
    logic [COST_W:0]    r_m;
    t_move              r_mv;
    logic               r_ok;
    logic [COST_W:0]    sum;

    always_comb begin
        diff    = {i_a[SB-1], i_a[SB-1:0]} - {i_b[SB-1], i_b[SB-1:0]};
        mag     = diff[SB] ? (~diff + 1'b1) : diff;
        mag_x   = 34'(mag);
        big     = |mag_x[33:24];
        sq      = mag_x[23:0] * mag_x[23:0];
        ad      = i_d[DW-1] ? DW'(-i_d) : DW'(i_d);
        ad_sq   = ad * ad;
        lc_miss = COST_W'({(2*DW+3)'(ad_sq) + ((2*DW+3)'(ad_sq) << 2), 16'd0});
        if (i_a[SB] || i_b[SB]) begin
            n_lc = lc_miss;
        end else if (big) begin
            n_lc = COST_MAX[COST_W-1:0];
        end else begin
            n_lc = sq;
        end

        dg_e = i_ctl.dg_ok ? i_dg : COST_INF;
        lf_e = i_ctl.lf_ok ? i_lf : COST_INF;
        up_e = i_ctl.up_ok ? i_up : COST_INF;
        // diagonal wins ties, then left, then up
        if (dg_e <= lf_e && dg_e <= up_e) begin
            n_m  = dg_e;
            n_mv = MV_DIAG;
        end else if (lf_e <= up_e) begin
            n_m  = lf_e;
            n_mv = MV_LEFT;
        end else begin
            n_m  = up_e;
            n_mv = MV_UP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lc <= n_lc;
            r_m  <= n_m;
            r_mv <= n_mv;
            r_ok <= i_ctl.in_range;
        end
    end

    always_comb begin
        sum = r_m + {1'b0, r_lc};
        if (!r_ok) begin
            o_cost = COST_INF;
            o_move = MV_NONE;
        end else if (r_m[COST_W]) begin
            o_cost = {1'b0, r_lc};
            o_move = MV_NONE;
        end else begin
            o_cost = sum[COST_W] ? COST_MAX : sum;
            o_move = r_mv;
        end
    end

endmodule

// ===== sv/banded_dtw_aligner.sv =====
`timescale 1ns / 1ps
// ============================================================================
// banded_dtw_aligner
// Banded dynamic time warping over two sample streams, with path read-back.
// ============================================================================
// Use:
//   i_in carries commands. A load transfer stores one sample pair and returns
//   nothing. A load with last_sample set starts the alignment over all
//   stored pairs and returns one report (kind 0) with the path length. A
//   read transfer returns one path entry (kind 1) through the path read
//   register and the output register, or out_of_range when the index is
//   past the stored path. Each cell passes the cost memory read, the cost
//   unit register and write-back; each backtrack step the move memory read.
//   One command is in flight at a time; i_in.ready is high only while idle.
//   The result waits in the output register while o_out.ready is low, and
//   loads without last are still taken meanwhile.
//   Reset clears the sample count, the path length (reads then report an
//   empty path) and sets the window half width to 8. The user must write
//   the window register through i_cfg_we / i_cfg_wdata only while idle;
//   the block itself does not enforce it.
// ============================================================================
module banded_dtw_aligner #(
    parameter int MAX_LEN     = bdtw_pkg::MAX_LEN_DEF,
    parameter int MAX_WINDOW  = bdtw_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = bdtw_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bdtw_pkg::WIN_W-1:0] i_cfg_wdata,
    bdtw_in_if.sink                   i_in,
    bdtw_out_if.source                o_out
);
    import bdtw_pkg::*;

    localparam int BAND       = 2 * MAX_WINDOW + 1;
    localparam int PATH_DEPTH = 2 * MAX_LEN - 2;
    localparam int JW         = $clog2(MAX_LEN);
    localparam int JW1        = JW + 1;
    localparam int NW         = $clog2(MAX_LEN + 1);
    localparam int IW         = $clog2(BAND + 1);
    localparam int DW         = $clog2(MAX_WINDOW + 2) + 2;
    localparam int KW         = ((NW > DW) ? NW : DW) + 2;
    localparam int MD         = MAX_LEN * BAND;
    localparam int MAW        = $clog2(MD);
    localparam int LW         = $clog2(PATH_DEPTH + 1);
    localparam int PAW        = $clog2(PATH_DEPTH);
    localparam int CW         = (LW > IDX_W) ? LW : IDX_W;
    localparam int SW         = SAMPLE_BITS + 1;

    localparam logic signed [DW-1:0] MWS = DW'(MAX_WINDOW);

    // ---------------------------------------------------------------- memories
    logic [SW-1:0]     first_mem  [MAX_LEN];
    logic [SW-1:0]     second_mem [MAX_LEN];
    logic [COST_W:0]   cost_mem   [2**(IW+1)];   // two banks: row parity
    logic [1:0]        move_mem   [MD];
    logic [21:0]       path_mem   [PATH_DEPTH];

    // ---------------------------------------------------------------- state
    t_state              r_state, n_state;
    logic [WIN_W-1:0]    r_win;
    logic [NW-1:0]       r_cnt_smp;
    logic [NW-1:0]       r_n;
    logic [JW-1:0]       r_j;
    logic signed [DW-1:0] r_d;
    logic [MAW-1:0]      r_base;
    logic [COST_W:0]     r_left;
    logic [LW-1:0]       r_bt_cnt;
    logic                r_jneg;
    logic [LW-1:0]       r_len;
    logic                r_rd_hit;

    logic [SW-1:0]       r_a_q, r_b_q;
    logic [COST_W:0]     r_dg_q, r_up_q;
    logic [1:0]          r_mv_q;
    logic [21:0]         r_path_q;

    logic                r_out_valid;
    logic                r_out_kind;
    logic [10:0]         r_out_len;
    logic [10:0]         r_out_ia;
    logic [10:0]         r_out_ib;
    logic                r_out_oor;

    // ---------------------------------------------------------------- derived
    logic signed [DW-1:0] w_s;
    logic signed [KW-1:0] k_s;
    logic                 in_range;
    logic [IW-1:0]        idx;
    logic [IW-1:0]        idx_up;
    logic [MAW-1:0]       mv_addr;
    logic                 accept;
    logic                 out_free;
    logic                 last_row;
    logic                 row_end;
    logic                 bt_stop;
    logic                 smp_room;
    t_move                bt_mv;
    t_cell_ctl            cell_ctl;
    logic [COST_W:0]      cell_cost;
    t_move                cell_move;
    logic [10:0]          ent_ia, ent_ib;

    // strobes from the output decoder
    logic s_row_rd, s_cell_rd, s_calc, s_cell_wr, s_bt_rd, s_bt_step;
    logic s_load_rep, s_load_rd;

    // Clamp the window to what the band storage holds
    assign w_s      = (32'(r_win) > MAX_WINDOW) ? MWS : DW'(r_win);
    assign k_s      = $signed(KW'(r_j)) + KW'(r_d);
    assign in_range = !k_s[KW-1] && (k_s < $signed(KW'(r_n)));
    assign idx      = IW'(r_d + MWS);
    assign idx_up   = IW'(idx + IW'(1));
    assign mv_addr  = r_base + MAW'(idx);
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign last_row = (NW'(r_j) == (r_n - NW'(1)));
    assign row_end  = (r_d == w_s);
    assign smp_room = (32'(r_cnt_smp) < MAX_LEN);
    assign bt_stop  = r_jneg || (r_d < -w_s) || (r_d > w_s) ||
                      (32'(r_bt_cnt) >= PATH_DEPTH);
    assign bt_mv    = t_move'(r_mv_q);
    assign ent_ia   = 11'(JW1'(r_j) + JW1'(1));
    assign ent_ib   = 11'(k_s + KW'(1));

    always_comb begin
        cell_ctl.dg_ok    = (r_j != '0);
        cell_ctl.lf_ok    = (r_d != -w_s);
        cell_ctl.up_ok    = (r_j != '0) && (r_d != w_s);
        cell_ctl.in_range = in_range;
    end

    bdtw_cost_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DW          (DW)
    ) u_cost (
        .i_clk  (i_clk),
        .i_en   (s_calc),
        .i_a    (r_a_q),
        .i_b    (r_b_q),
        .i_d    (r_d),
        .i_dg   (r_dg_q),
        .i_lf   (r_left),
        .i_up   (r_up_q),
        .i_ctl  (cell_ctl),
        .o_cost (cell_cost),
        .o_move (cell_move)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in.operation == OP_READ) begin
                        n_state = ST_RD_OUT;
                    end else if (i_in.last_sample) begin
                        n_state = ST_ROW;
                    end
                end
            end
            ST_ROW:       n_state = ST_CELL_RD;
            ST_CELL_RD:   n_state = ST_CELL_CALC;
            ST_CELL_CALC: n_state = ST_CELL_WR;
            ST_CELL_WR: begin
                if (!row_end) begin
                    n_state = ST_CELL_RD;
                end else if (last_row) begin
                    n_state = ST_BT_RD;
                end else begin
                    n_state = ST_ROW;
                end
            end
            ST_BT_RD:   n_state = bt_stop ? ST_REPORT : ST_BT_STEP;
            ST_BT_STEP: n_state = (bt_mv == MV_NONE) ? ST_REPORT : ST_BT_RD;
            ST_REPORT:  n_state = out_free ? ST_IDLE : ST_REPORT;
            ST_RD_OUT:  n_state = out_free ? ST_IDLE : ST_RD_OUT;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_row_rd   = 1'b0;
        s_cell_rd  = 1'b0;
        s_calc     = 1'b0;
        s_cell_wr  = 1'b0;
        s_bt_rd    = 1'b0;
        s_bt_step  = 1'b0;
        s_load_rep = 1'b0;
        s_load_rd  = 1'b0;
        i_in.ready = 1'b0;
        case (r_state)
            ST_IDLE:      i_in.ready = 1'b1;
            ST_ROW:       s_row_rd   = 1'b1;
            ST_CELL_RD:   s_cell_rd  = 1'b1;
            ST_CELL_CALC: s_calc     = 1'b1;
            ST_CELL_WR:   s_cell_wr  = 1'b1;
            ST_BT_RD:     s_bt_rd    = !bt_stop;
            ST_BT_STEP:   s_bt_step  = 1'b1;
            ST_REPORT:    s_load_rep = out_free;
            ST_RD_OUT:    s_load_rd  = out_free;
            default:      i_in.ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (i_cfg_we) begin
            r_win <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------- memories
    always_ff @(posedge i_clk) begin
        if (accept && i_in.operation == OP_LOAD && smp_room) begin
            first_mem[r_cnt_smp[JW-1:0]]  <= {i_in.missing_a, i_in.sample_a};
            second_mem[r_cnt_smp[JW-1:0]] <= {i_in.missing_b, i_in.sample_b};
        end
        if (s_row_rd) begin
            r_a_q <= first_mem[r_j];
        end
        if (s_cell_rd) begin
            r_b_q <= second_mem[k_s[JW-1:0]];
        end
    end

    // Previous row sits in the bank of opposite parity
    always_ff @(posedge i_clk) begin
        if (s_cell_wr) begin
            cost_mem[{r_j[0], idx}] <= cell_cost;
        end
        if (s_cell_rd) begin
            r_dg_q <= cost_mem[{~r_j[0], idx}];
            r_up_q <= cost_mem[{~r_j[0], idx_up}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_cell_wr) begin
            move_mem[mv_addr] <= cell_move;
        end
        if (s_bt_rd) begin
            r_mv_q <= move_mem[mv_addr];
        end
    end

    // Path entries go in backtrack order; reads mirror the index
    always_ff @(posedge i_clk) begin
        if (s_bt_step && bt_mv != MV_NONE) begin
            path_mem[r_bt_cnt[PAW-1:0]] <= {ent_ia, ent_ib};
        end
        if (accept && i_in.operation == OP_READ) begin
            r_path_q <= path_mem[PAW'(r_len - LW'(1) - LW'(i_in.path_index))];
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_smp <= '0;
            r_len     <= '0;
        end else begin
            if (accept && i_in.operation == OP_LOAD) begin
                if (i_in.last_sample) begin
                    r_n       <= r_cnt_smp + NW'(smp_room);
                    r_cnt_smp <= '0;
                    r_j       <= '0;
                    r_base    <= '0;
                    r_d       <= -w_s;
                end else if (smp_room) begin
                    r_cnt_smp <= r_cnt_smp + NW'(1);
                end
            end
            if (accept && i_in.operation == OP_READ) begin
                r_rd_hit <= (CW'(i_in.path_index) < CW'(r_len));
            end
            if (s_cell_wr) begin
                r_left <= cell_cost;
                if (!row_end) begin
                    r_d <= r_d + DW'(1);
                end else if (last_row) begin
                    // start the walk back from the end cell
                    r_d      <= '0;
                    r_bt_cnt <= '0;
                    r_jneg   <= 1'b0;
                end else begin
                    r_j    <= r_j + JW'(1);
                    r_base <= r_base + MAW'(BAND);
                    r_d    <= -w_s;
                end
            end
            if (r_state == ST_BT_RD && bt_stop) begin
                r_len <= r_bt_cnt;
            end
            if (s_bt_step) begin
                if (bt_mv == MV_NONE) begin
                    r_len <= r_bt_cnt;
                end else begin
                    r_bt_cnt <= r_bt_cnt + LW'(1);
                    if (bt_mv == MV_LEFT) begin
                        r_d <= r_d - DW'(1);
                    end else begin
                        if (bt_mv == MV_UP) begin
                            r_d <= r_d + DW'(1);
                        end
                        if (r_j == '0) begin
                            r_jneg <= 1'b1;
                        end else begin
                            r_j    <= r_j - JW'(1);
                            r_base <= r_base - MAW'(BAND);
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load_rep) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= KIND_REPORT;
            r_out_len   <= 11'(r_len);
            r_out_ia    <= '0;
            r_out_ib    <= '0;
            r_out_oor   <= 1'b0;
        end else if (s_load_rd) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= KIND_ENTRY;
            r_out_len   <= 11'(r_len);
            r_out_ia    <= r_rd_hit ? r_path_q[21:11] : 11'd0;
            r_out_ib    <= r_rd_hit ? r_path_q[10:0]  : 11'd0;
            r_out_oor   <= !r_rd_hit;
        end else if (o_out.ready) begin
            // drop the item once its transfer completes
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out_kind;
    assign o_out.path_length  = r_out_len;
    assign o_out.index_a      = r_out_ia;
    assign o_out.index_b      = r_out_ib;
    assign o_out.out_of_range = r_out_oor;

    // ---------------------------------------------------------------- checks
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= PATH_DEPTH)
        else $error("stored path length beyond path store depth");

    a_d_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CELL_WR) |-> (r_d >= -w_s && r_d <= w_s))
        else $error("cell written outside the band");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CELL_RD) |-> (NW'(r_j) < r_n))
        else $error("row index past sample count");

    a_report_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_out_kind == KIND_REPORT) |->
            ($past(r_state) == ST_REPORT))
        else $error("report issued outside report state");

endmodule
